// ===== hw/rtl/gtw_pkg.sv =====
// Shared constants, types and rounding helpers for the gimbal thrust wrench block.
`timescale 1ns / 1ps

package gtw_pkg;

    localparam int GTW_CORDIC_STAGES = 16;
    localparam int GTW_ANG_W         = 34;   // CORDIC x, y and z width, Q.30
    localparam int GTW_WIDE_W        = 72;   // working width for round and saturate

    localparam logic signed [GTW_ANG_W-1:0] GTW_K       = 34'sd652032874;
    localparam logic signed [GTW_ANG_W-1:0] GTW_PI      = 34'sd3373259426;
    localparam logic signed [GTW_ANG_W-1:0] GTW_HALF_PI = 34'sd1686629713;

    // register indexes of the configuration port
    localparam logic [1:0] GTW_REG_GIMBAL  = 2'd0;
    localparam logic [1:0] GTW_REG_MAX     = 2'd1;
    localparam logic [1:0] GTW_REG_NOZZLE  = 2'd2;

    localparam logic [31:0] GTW_ATAN [24] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
        32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149,
        32'd1048575,   32'd524287,    32'd262143,    32'd131071,    32'd65535,
        32'd32767,     32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127
    };

    // item data that travels alongside the CORDIC stages
    typedef struct packed {
        logic signed [31:0] thrust;
        logic signed [32:0] arm;     // moment arm, Q16.16, exact
        logic               gimbal;
        logic               tpos;
        logic               neg;     // quadrant fold applied to the angle
    } gtw_side_t;

    function automatic logic signed [GTW_ANG_W-1:0] gtw_atan(input int idx);
        return GTW_ANG_W'($signed({1'b0, GTW_ATAN[idx]}));
    endfunction

    // add half and floor
    function automatic logic signed [GTW_WIDE_W-1:0] gtw_round(
        input logic signed [GTW_WIDE_W-1:0] v,
        input int                           sh
    );
        logic signed [GTW_WIDE_W-1:0] half;
        half = GTW_WIDE_W'(1) <<< (sh - 1);
        return (v + half) >>> sh;
    endfunction

    function automatic logic signed [31:0] gtw_sat32(input logic signed [GTW_WIDE_W-1:0] v);
        logic signed [GTW_WIDE_W-1:0] hi;
        logic signed [GTW_WIDE_W-1:0] lo;
        hi = GTW_WIDE_W'(33'sh0_7FFF_FFFF);
        lo = -hi - GTW_WIDE_W'(1);
        if (v > hi) return 32'sh7FFF_FFFF;
        else if (v < lo) return 32'sh8000_0000;
        else return v[31:0];
    endfunction

    function automatic logic signed [47:0] gtw_sat48(input logic signed [GTW_WIDE_W-1:0] v);
        logic signed [GTW_WIDE_W-1:0] hi;
        logic signed [GTW_WIDE_W-1:0] lo;
        hi = GTW_WIDE_W'(49'sh0_7FFF_FFFF_FFFF);
        lo = -hi - GTW_WIDE_W'(1);
        if (v > hi) return 48'sh7FFF_FFFF_FFFF;
        else if (v < lo) return 48'sh8000_0000_0000;
        else return v[47:0];
    endfunction

endpackage

// ===== hw/rtl/gtw_cordic.sv =====
// Pipelined rotation-mode CORDIC, one register stage per iteration.
`timescale 1ns / 1ps

module gtw_cordic #(
    parameter int STAGES = gtw_pkg::GTW_CORDIC_STAGES
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic signed [gtw_pkg::GTW_ANG_W-1:0]   z_in,
    output logic signed [gtw_pkg::GTW_ANG_W-1:0]   cos_out,
    output logic signed [gtw_pkg::GTW_ANG_W-1:0]   sin_out
);
    import gtw_pkg::*;

    logic signed [GTW_ANG_W-1:0] x_reg [1:STAGES];
    logic signed [GTW_ANG_W-1:0] y_reg [1:STAGES];
    logic signed [GTW_ANG_W-1:0] z_reg [1:STAGES];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [GTW_ANG_W-1:0] xi;
        logic signed [GTW_ANG_W-1:0] yi;
        logic signed [GTW_ANG_W-1:0] zi;
        logic signed [GTW_ANG_W-1:0] xs;
        logic signed [GTW_ANG_W-1:0] ys;
        if (i == 0) begin : g_seed
            // first iteration starts from the gain-corrected seed
            assign xi = GTW_K;
            assign yi = '0;
            assign zi = z_in;
        end else begin : g_link
            assign xi = x_reg[i];
            assign yi = y_reg[i];
            assign zi = z_reg[i];
        end
        assign xs = xi >>> i;
        assign ys = yi >>> i;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!zi[GTW_ANG_W-1]) begin
                    x_reg[i+1] <= xi - ys;
                    y_reg[i+1] <= yi + xs;
                    z_reg[i+1] <= zi - gtw_atan(i);
                end else begin
                    x_reg[i+1] <= xi + ys;
                    y_reg[i+1] <= yi - xs;
                    z_reg[i+1] <= zi + gtw_atan(i);
                end
            end
        end
    end

    assign cos_out = x_reg[STAGES];
    assign sin_out = y_reg[STAGES];

endmodule

// ===== hw/rtl/gimbal_thrust_wrench_core.sv =====
// Top level: gimbaled engine thrust to body force, moment and control gain.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  cfg     | cfg_we             | cfg_index, cfg_data
//  s_      | s_valid / s_ready  | thrust, pitch/yaw command, cg station, cg_known
//  m_      | m_valid / m_ready  | force x/y/z, moment pitch/yaw, gain, gain_valid
//
// One request per cycle sustained unless m_ready holds the output. An input
// stage (clamp, quadrant fold), one stage per CORDIC iteration, then seven
// stages of multiply / round-and-saturate, the last being the output register.
// Whole pipeline advances together; it holds while the output waits on m_ready.
// Reset (aresetn low, synchronous) clears the valid bits and loads the register
// defaults: gimbal present, limit 819, nozzle station 0.
`timescale 1ns / 1ps

module gimbal_thrust_wrench_core #(
    parameter int CORDIC_STAGES = gtw_pkg::GTW_CORDIC_STAGES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_thrust,
    input  logic signed [15:0] s_pitch_command,
    input  logic signed [15:0] s_yaw_command,
    input  logic signed [31:0] s_cg_station,
    input  logic               s_cg_known,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_force_x,
    output logic signed [31:0] m_force_y,
    output logic signed [31:0] m_force_z,
    output logic signed [47:0] m_moment_pitch,
    output logic signed [47:0] m_moment_yaw,
    output logic signed [47:0] m_control_gain,
    output logic               m_gain_valid
);
    import gtw_pkg::*;

    localparam int AW = GTW_ANG_W;
    localparam int WW = GTW_WIDE_W;

    // ---------------- configuration registers
    logic               gimbal_reg;
    logic [14:0]        max_gimbal_reg;
    logic signed [31:0] nozzle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gimbal_reg     <= 1'b1;
            max_gimbal_reg <= 15'd819;
            nozzle_reg     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                GTW_REG_GIMBAL: gimbal_reg     <= cfg_data[0];
                GTW_REG_MAX:    max_gimbal_reg <= cfg_data[14:0];
                GTW_REG_NOZZLE: nozzle_reg     <= cfg_data;
                default: ;      // unused index
            endcase
        end
    end

    // ---------------- global advance: every stage moves unless output is stuck
    logic en;
    logic out_vld_reg;
    assign en      = !out_vld_reg || m_ready;
    assign s_ready = en;

    // ---------------- input stage: clamp and fold both angles
    function automatic logic signed [15:0] clamp_ang(
        input logic signed [15:0] a,
        input logic        [14:0] m
    );
        logic signed [16:0] mp;
        logic signed [16:0] a17;
        mp  = $signed({2'b00, m});
        a17 = 17'(a);
        if (a17 > mp) return mp[15:0];
        else if (a17 < -mp) return 16'(-mp);
        else return a;
    endfunction

    function automatic logic signed [AW:0] fold_ang(input logic signed [15:0] a);
        logic signed [AW-1:0] z;
        logic                 neg;
        z   = AW'($signed({a, 17'b0}));
        neg = 1'b0;
        if (z > GTW_HALF_PI) begin
            z   = z - GTW_PI;
            neg = 1'b1;
        end else if (z < -GTW_HALF_PI) begin
            z   = z + GTW_PI;
            neg = 1'b1;
        end
        return {neg, z};
    endfunction

    logic signed [AW:0]   p_fold;
    logic signed [AW:0]   y_fold;
    logic signed [AW-1:0] zp_reg;
    logic signed [AW-1:0] zy_reg;
    logic                 yneg_reg;
    gtw_side_t            side_in;

    assign p_fold = fold_ang(clamp_ang(s_pitch_command, max_gimbal_reg));
    assign y_fold = fold_ang(clamp_ang(s_yaw_command,   max_gimbal_reg));

    always_comb begin
        side_in.thrust = s_thrust;
        side_in.arm    = 33'(nozzle_reg) - (s_cg_known ? 33'(s_cg_station) : 33'sd0);
        side_in.gimbal = gimbal_reg;
        side_in.tpos   = (s_thrust > 32'sd0);
        side_in.neg    = p_fold[AW];
    end

    // side line, slot 0 = input stage, slot CORDIC_STAGES = CORDIC output
    gtw_side_t side_reg [CORDIC_STAGES+1];
    logic      yneg_line_reg [CORDIC_STAGES+1];
    logic      vld_reg  [CORDIC_STAGES+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            zp_reg           <= p_fold[AW-1:0];
            zy_reg           <= y_fold[AW-1:0];
            side_reg[0]      <= side_in;
            yneg_line_reg[0] <= y_fold[AW];
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                side_reg[i+1]      <= side_reg[i];
                yneg_line_reg[i+1] <= yneg_line_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= CORDIC_STAGES; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int i = 0; i < CORDIC_STAGES; i++) vld_reg[i+1] <= vld_reg[i];
        end
    end

    assign yneg_reg = yneg_line_reg[CORDIC_STAGES];

    // ---------------- CORDIC pair
    logic signed [AW-1:0] cp_raw, sp_raw, cy_raw, sy_raw;

    gtw_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
        .aclk    (aclk),
        .en      (en),
        .z_in    (zp_reg),
        .cos_out (cp_raw),
        .sin_out (sp_raw)
    );

    gtw_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_yaw (
        .aclk    (aclk),
        .en      (en),
        .z_in    (zy_reg),
        .cos_out (cy_raw),
        .sin_out (sy_raw)
    );

    // ---------------- post stages B..H; valid bits follow the data
    gtw_side_t side_b_reg, side_c_reg, side_d_reg, side_e_reg, side_f_reg, side_g_reg;
    logic      vb_reg, vc_reg, vd_reg, ve_reg, vf_reg, vg_reg;

    // B: undo the quadrant fold
    logic signed [AW-1:0] cp_reg, sp_reg, cy_reg, sy_reg;
    // C: trig products
    logic signed [2*AW-1:0] pcc_reg, pcs_reg;
    logic signed [AW-1:0]   sp_c_reg;
    // D: trig products rounded to Q.30
    logic signed [AW-1:0] cc_reg, cs_reg, sp_d_reg;
    // E: thrust products
    logic signed [AW+31:0] pfx_reg, pfy_reg, pfz_reg;
    logic signed [64:0]    pg_reg;
    // F: saturated forces and gain
    logic signed [31:0] fx_reg, fy_reg, fz_reg, fx_g_reg, fy_g_reg, fz_g_reg;
    logic signed [47:0] gain_f_reg, gain_g_reg;
    // G: moment products
    logic signed [64:0] pmp_reg, pmy_reg;

    logic signed [WW-1:0] rcc, rcs;
    assign rcc = gtw_round(WW'(pcc_reg), 30);
    assign rcs = gtw_round(WW'(pcs_reg), 30);

    always_ff @(posedge aclk) begin
        if (en) begin
            cp_reg     <= side_reg[CORDIC_STAGES].neg ? -cp_raw : cp_raw;
            sp_reg     <= side_reg[CORDIC_STAGES].neg ? -sp_raw : sp_raw;
            cy_reg     <= yneg_reg ? -cy_raw : cy_raw;
            sy_reg     <= yneg_reg ? -sy_raw : sy_raw;
            side_b_reg <= side_reg[CORDIC_STAGES];

            pcc_reg    <= cp_reg * cy_reg;
            pcs_reg    <= cp_reg * sy_reg;
            sp_c_reg   <= sp_reg;
            side_c_reg <= side_b_reg;

            cc_reg     <= rcc[AW-1:0];
            cs_reg     <= rcs[AW-1:0];
            sp_d_reg   <= sp_c_reg;
            side_d_reg <= side_c_reg;

            pfx_reg    <= side_d_reg.thrust * cc_reg;
            pfy_reg    <= side_d_reg.thrust * cs_reg;
            pfz_reg    <= side_d_reg.thrust * sp_d_reg;
            pg_reg     <= side_d_reg.arm * side_d_reg.thrust;
            side_e_reg <= side_d_reg;

            fx_reg     <= gtw_sat32(gtw_round(WW'(pfx_reg), 30));
            fy_reg     <= gtw_sat32(gtw_round(-WW'(pfy_reg), 30));
            fz_reg     <= gtw_sat32(gtw_round(WW'(pfz_reg), 30));
            gain_f_reg <= gtw_sat48(gtw_round(WW'(pg_reg), 16));
            side_f_reg <= side_e_reg;

            pmp_reg    <= side_f_reg.arm * fz_reg;
            pmy_reg    <= side_f_reg.arm * fy_reg;
            fx_g_reg   <= fx_reg;
            fy_g_reg   <= fy_reg;
            fz_g_reg   <= fz_reg;
            gain_g_reg <= gain_f_reg;
            side_g_reg <= side_f_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0; vc_reg <= 1'b0; vd_reg <= 1'b0;
            ve_reg <= 1'b0; vf_reg <= 1'b0; vg_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= vld_reg[CORDIC_STAGES];
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
            vg_reg <= vf_reg;
        end
    end

    // ---------------- H: moments, special cases, output register
    logic signed [31:0] fx_next, fy_next, fz_next;
    logic signed [47:0] mp_next, my_next, gain_next;
    logic               gv_next;
    logic signed [31:0] fx_out_reg, fy_out_reg, fz_out_reg;
    logic signed [47:0] mp_out_reg, my_out_reg, gain_out_reg;
    logic               gv_out_reg;

    always_comb begin
        fx_next   = '0;
        fy_next   = '0;
        fz_next   = '0;
        mp_next   = '0;
        my_next   = '0;
        gain_next = '0;
        gv_next   = 1'b0;
        priority if (!side_g_reg.gimbal) begin
            fx_next = side_g_reg.thrust;          // fixed mount: axial thrust as given
        end else if (side_g_reg.tpos) begin
            fx_next   = fx_g_reg;
            fy_next   = fy_g_reg;
            fz_next   = fz_g_reg;
            mp_next   = gtw_sat48(gtw_round(WW'(pmp_reg), 16));
            my_next   = gtw_sat48(gtw_round(-WW'(pmy_reg), 16));
            gain_next = gain_g_reg;
            gv_next   = 1'b1;
        end else begin
            // gimbaled, no positive thrust: all zero
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fx_out_reg   <= fx_next;
            fy_out_reg   <= fy_next;
            fz_out_reg   <= fz_next;
            mp_out_reg   <= mp_next;
            my_out_reg   <= my_next;
            gain_out_reg <= gain_next;
            gv_out_reg   <= gv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) out_vld_reg <= 1'b0;
        else if (en)  out_vld_reg <= vg_reg;
    end

    assign m_valid        = out_vld_reg;
    assign m_force_x      = fx_out_reg;
    assign m_force_y      = fy_out_reg;
    assign m_force_z      = fz_out_reg;
    assign m_moment_pitch = mp_out_reg;
    assign m_moment_yaw   = my_out_reg;
    assign m_control_gain = gain_out_reg;
    assign m_gain_valid   = gv_out_reg;

endmodule

// ===== dv/gimbal_thrust_wrench_core_test.sv =====
// Self-checking bench for the gimbal thrust wrench core: random and directed requests.
`timescale 1ns / 1ps

module gimbal_thrust_wrench_core_test;
    import gtw_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 40;      // pipeline is CORDIC_STAGES + 8 deep
    localparam int ITEMS_PER_PHASE = 280;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = GTW_REG_GIMBAL;
    logic [31:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_thrust = '0;
    logic signed [15:0] s_pitch_command = '0;
    logic signed [15:0] s_yaw_command = '0;
    logic signed [31:0] s_cg_station = '0;
    logic               s_cg_known = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_force_x, m_force_y, m_force_z;
    logic signed [47:0] m_moment_pitch, m_moment_yaw, m_control_gain;
    logic               m_gain_valid;

    // one computed wrench
    typedef struct {
        logic signed [31:0] fx, fy, fz;
        logic signed [47:0] mp, my, gain;
        logic               valid;
    } wrench_t;

    gimbal_thrust_wrench_core DUT (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Wrench predictor and store of expected wrenches
    // ------------------------------------------------------------------
    class wrench_board;
        wrench_t pending[$];
        int      errors;
        logic    gimbal_on;
        int      limit;
        logic signed [31:0] nozzle;

        function new();
            errors = 0;
            gimbal_on = 1'b1;
            limit = 819;
            nozzle = '0;
        endfunction

        function void report(string what, logic signed [47:0] got, logic signed [47:0] want);
            $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            errors++;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == GTW_REG_GIMBAL) gimbal_on = val[0];
            else if (idx == GTW_REG_MAX) limit = int'(val[14:0]);
            else if (idx == GTW_REG_NOZZLE) nozzle = val;
        endfunction

        function logic signed [95:0] rnd(logic signed [95:0] v, int sh);
            return (v + (96'sd1 <<< (sh - 1))) >>> sh;
        endfunction

        function logic signed [95:0] sat(logic signed [95:0] v, int w);
            logic signed [95:0] hi, lo;
            hi = (96'sd1 <<< (w - 1)) - 96'sd1;
            lo = -hi - 96'sd1;
            return v > hi ? hi : (v < lo ? lo : v);
        endfunction

        // folded CORDIC rotation, Q.30 out
        function void rotate(int ang, output longint sn, output longint cs);
            longint z, x, y, xs, ys;
            bit     flip;
            z = longint'(ang) * 131072;
            x = 652032874;
            y = 0;
            flip = 0;
            if (z > longint'(GTW_HALF_PI)) begin
                z -= longint'(GTW_PI);
                flip = 1;
            end else if (z < -longint'(GTW_HALF_PI)) begin
                z += longint'(GTW_PI);
                flip = 1;
            end
            for (int i = 0; i < GTW_CORDIC_STAGES && i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x -= ys; y += xs; z -= longint'(GTW_ATAN[i]);
                end else begin
                    x += ys; y -= xs; z += longint'(GTW_ATAN[i]);
                end
            end
            sn = flip ? -y : y;
            cs = flip ? -x : x;
        endfunction

        function void note(logic signed [31:0] t, logic signed [15:0] pc_in,
                           logic signed [15:0] yc_in, logic signed [31:0] cg, logic cg_ok);
            wrench_t w;
            int pc, yc;
            longint sp, cp, sy, cy;
            logic signed [95:0] cc, csy, tw, arm;
            w = '{fx: '0, fy: '0, fz: '0, mp: '0, my: '0, gain: '0, valid: 1'b0};
            if (!gimbal_on) begin
                w.fx = t;
            end else if (t > 0) begin
                pc = pc_in;
                yc = yc_in;
                if (pc > limit) pc = limit; else if (pc < -limit) pc = -limit;
                if (yc > limit) yc = limit; else if (yc < -limit) yc = -limit;
                rotate(pc, sp, cp);
                rotate(yc, sy, cy);
                cc  = rnd(96'(cp) * 96'(cy), 30);
                csy = rnd(96'(cp) * 96'(sy), 30);
                tw  = 96'(t);
                w.fx = 32'(sat(rnd(tw * cc, 30), 32));
                w.fy = 32'(sat(rnd(-(tw * csy), 30), 32));
                w.fz = 32'(sat(rnd(tw * 96'(sp), 30), 32));
                arm = 96'(nozzle);
                if (cg_ok) arm = arm - 96'(cg);
                w.mp   = 48'(sat(rnd(arm * 96'(w.fz), 16), 48));
                w.my   = 48'(sat(rnd(-(arm * 96'(w.fy)), 16), 48));
                w.gain = 48'(sat(rnd(arm * tw, 16), 48));
                w.valid = 1'b1;
            end
            pending.push_back(w);
        endfunction

        function void check(wrench_t got);
            wrench_t want;
            if (pending.size() == 0) begin
                report("unexpected result", 48'(got.fx), '0);
                return;
            end
            want = pending.pop_front();
            if (got.fx != want.fx) report("force_x", 48'(got.fx), 48'(want.fx));
            if (got.fy != want.fy) report("force_y", 48'(got.fy), 48'(want.fy));
            if (got.fz != want.fz) report("force_z", 48'(got.fz), 48'(want.fz));
            if (got.mp != want.mp) report("moment_pitch", got.mp, want.mp);
            if (got.my != want.my) report("moment_yaw", got.my, want.my);
            if (got.gain != want.gain) report("control_gain", got.gain, want.gain);
            if (got.valid != want.valid) report("gain_valid", 48'(got.valid), 48'(want.valid));
        endfunction
    endclass

    wrench_board board = new();
    bit          calm = 0;         // no idling on either side while set
    int          cycles = 0;

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random back-pressure, driven on the falling edge
    always @(negedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
    end

    // sample completed results on the rising edge
    always @(posedge aclk) begin
        wrench_t r;
        if (aresetn && m_valid && m_ready) begin
            r.fx = m_force_x; r.fy = m_force_y; r.fz = m_force_z;
            r.mp = m_moment_pitch; r.my = m_moment_yaw; r.gain = m_control_gain;
            r.valid = m_gain_valid;
            board.check(r);
        end
    end

    // ------------------------------------------------------------------
    // Drive tasks: every call is entered just after a falling edge
    // ------------------------------------------------------------------
    task automatic send(logic signed [31:0] t, logic signed [15:0] pc, logic signed [15:0] yc,
                        logic signed [31:0] cg, logic ok);
        if (!calm && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_thrust <= t;
        s_pitch_command <= pc;
        s_yaw_command <= yc;
        s_cg_station <= cg;
        s_cg_known <= ok;
        do @(posedge aclk); while (!s_ready);
        board.note(t, pc, yc, cg, ok);
        @(negedge aclk);
    endtask

    // wait for the pipeline to empty, then let it settle
    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        board.set_reg(idx, val);
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_phase(logic gimbal, logic [14:0] lim, logic [31:0] noz);
        drain();
        write_reg(GTW_REG_GIMBAL, {31'(0), gimbal});
        write_reg(GTW_REG_MAX, {17'(0), lim});
        write_reg(GTW_REG_NOZZLE, noz);
    endtask

    task automatic directed();
        send(32'sh7FFF_FFFF, 16'sd25736, -16'sd25736, 32'sh8000_0000, 1'b1);
        send(32'sh7FFF_FFFF, -16'sd25736, 16'sd25736, 32'sh7FFF_FFFF, 1'b1);
        send(32'sh8000_0000, 16'sd100, 16'sd100, 32'sd0, 1'b1);     // negative thrust
        send(32'sd0, 16'sd100, -16'sd100, 32'sd65536, 1'b1);       // zero thrust
        send(32'sd1, 16'sd0, 16'sd0, 32'sd0, 1'b0);
        send(-32'sd1, 16'sd0, 16'sd0, 32'sd0, 1'b0);
        send(32'sd256000, 16'sh7FFF, 16'sh8000, 32'sh1234_5678, 1'b0);  // out-of-range angles
        send(32'sd256000, 16'sh8000, 16'sh7FFF, 32'sh8000_0000, 1'b0);  // unknown CG
        send(32'sh7FFF_FFFF, 16'sh7FFF, 16'sh7FFF, 32'sh8000_0000, 1'b1);
        send(32'sd5000, -16'sd12868, 16'sd12868, -32'sd65536, 1'b1);
        send(32'sh4000_0000, 16'sd12869, -16'sd12869, 32'sd327680, 1'b1);
    endtask

    task automatic random_items(int n);
        logic signed [31:0] t, cg;
        logic signed [15:0] pc, yc;
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (sel < 55) t = $urandom_range(32'h7FFF_FFFF, 1);
            else if (sel < 70) t = $urandom_range(100000, 1);
            else if (sel < 85) t = $urandom;
            else if (sel < 92) t = ($urandom_range(1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            else t = -$signed(32'($urandom_range(1000000)));
            if ($urandom_range(99) < 70) begin
                pc = $signed(16'($urandom_range(51472))) - 16'sd25736;
                yc = $signed(16'($urandom_range(51472))) - 16'sd25736;
            end else begin
                pc = $urandom;
                yc = $urandom;
            end
            cg = ($urandom_range(1)) ? 32'($urandom) : $signed(32'($urandom_range(2000000))) - 1000000;
            send(t, pc, yc, cg, $urandom_range(1));
            if (i == n / 2) drain();      // hold off until the pipeline is empty
        end
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset defaults
        directed();
        random_items(ITEMS_PER_PHASE);

        set_phase(1'b1, 15'd25736, 32'h7FFF_FFFF);
        directed();
        calm = 1;
        random_items(ITEMS_PER_PHASE);
        calm = 0;

        set_phase(1'b1, 15'd0, 32'h8000_0000);
        random_items(ITEMS_PER_PHASE / 2);

        set_phase(1'b0, 15'h7FFF, $urandom);
        directed();
        random_items(ITEMS_PER_PHASE / 2);

        set_phase(1'b1, 15'h7FFF, $urandom);
        write_reg(2'd3, $urandom);         // unknown index is ignored
        directed();
        random_items(ITEMS_PER_PHASE);

        set_phase(1'b1, 15'($urandom_range(25736)), $signed(32'($urandom_range(20000000))) - 10000000);
        random_items(ITEMS_PER_PHASE);

        drain();
        if (board.pending.size() != 0)
            board.report("missing results", 48'(board.pending.size()), '0);
        if (board.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/gtw_pkg.sv
hw/rtl/gtw_cordic.sv
hw/rtl/gimbal_thrust_wrench_core.sv
dv/gimbal_thrust_wrench_core_test.sv
